// ===== rtl/core/tewf_pkg.sv =====
// Package with the shared types and constants of the transport endpoint.
`default_nettype none
package tewf_pkg;

  typedef enum logic [1:0] {
    CMD_APP     = 2'd0,
    CMD_SEGMENT = 2'd1,
    CMD_CLOSE   = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEG_DATA = 2'd0,
    SEG_ACK  = 2'd1,
    SEG_FIN  = 2'd2
  } seg_kind_t;

  localparam logic [1:0] CFG_INIT_SEQ = 2'd0;
  localparam logic [1:0] CFG_INIT_WIN = 2'd1;
  localparam logic [1:0] CFG_ADV_WIN  = 2'd2;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam logic [31:0] RESET_INIT_SEQ = 32'd1;
  localparam logic [15:0] RESET_WINDOW   = 16'd3072;

  localparam int QUEUE_DEPTH = 2;

  // One queued event for the back end. A FIN-ack entry expands into the
  // payload ack (when there is payload) and the ack of the FIN itself.
  typedef struct packed {
    seg_kind_t   kind;
    logic        fin_ack;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [9:0]  payload_len;
    logic [9:0]  deliver_len;
    logic        done;
  } desc_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tewf_front.sv =====
// Front end: connection state, configuration registers and event classification.
`default_nettype none
module tewf_front #(
  parameter int unsigned MAX_SEGMENT_BYTES = 536
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              accept,
  input  wire logic [1:0]        command,
  input  wire logic [15:0]       app_offered_len,
  input  wire logic [7:0]        peer_flags,
  input  wire logic [31:0]       peer_seq,
  input  wire logic [31:0]       peer_ack,
  input  wire logic [15:0]       peer_window,
  input  wire logic [9:0]        peer_payload_len,
  output logic                   desc_valid,
  output tewf_pkg::desc_t        desc
);

  localparam logic [10:0] MSS = 11'(MAX_SEGMENT_BYTES);

  logic [31:0] init_seq_r, init_seq_nxt;
  logic [15:0] init_win_r, init_win_nxt;
  logic [15:0] adv_win_r, adv_win_nxt;
  logic [31:0] next_seq_r, next_seq_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [31:0] win_end_r, win_end_nxt;
  logic        wait_r, wait_nxt;
  logic        fin_sent_r, fin_sent_nxt;
  logic        fin_rcvd_r, fin_rcvd_nxt;
  logic        fin_acked_r, fin_acked_nxt;
  logic        closed_r, closed_nxt;

  logic [9:0]  plen_c;
  logic [31:0] ack_base;
  logic [31:0] room;
  logic [10:0] room_c;
  logic [15:0] sent;

  always_comb begin
    plen_c   = ({1'b0, peer_payload_len} > MSS) ? MSS[9:0] : peer_payload_len;
    ack_base = peer_seq + {22'd0, plen_c};
    room     = win_end_r - next_seq_r;
    room_c   = (room > {21'd0, MSS}) ? MSS : room[10:0];
    sent     = (app_offered_len < {5'd0, room_c}) ? app_offered_len : {5'd0, room_c};
  end

  always_comb begin
    init_seq_nxt  = init_seq_r;
    init_win_nxt  = init_win_r;
    adv_win_nxt   = adv_win_r;
    next_seq_nxt  = next_seq_r;
    acked_nxt     = acked_r;
    win_end_nxt   = win_end_r;
    wait_nxt      = wait_r;
    fin_sent_nxt  = fin_sent_r;
    fin_rcvd_nxt  = fin_rcvd_r;
    fin_acked_nxt = fin_acked_r;
    closed_nxt    = closed_r;
    desc_valid    = 1'b0;
    desc          = '0;
    desc.seq      = next_seq_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        tewf_pkg::CFG_INIT_SEQ: begin
          init_seq_nxt  = cfg_data;
          next_seq_nxt  = cfg_data + 32'd1;
          acked_nxt     = cfg_data;
          win_end_nxt   = tewf_pkg::sat_add(cfg_data, {16'd0, init_win_r});
          wait_nxt      = 1'b0;
          fin_sent_nxt  = 1'b0;
          fin_rcvd_nxt  = 1'b0;
          fin_acked_nxt = 1'b0;
          closed_nxt    = 1'b0;
        end
        tewf_pkg::CFG_INIT_WIN: init_win_nxt = cfg_data[15:0];
        tewf_pkg::CFG_ADV_WIN:  adv_win_nxt = cfg_data[15:0];
        default: ;
      endcase
    end else if (accept && !closed_r) begin
      case (tewf_pkg::cmd_t'(command))
        tewf_pkg::CMD_APP: begin
          if (!wait_r) begin
            if (!(next_seq_r >= acked_r && next_seq_r < win_end_r)) begin
              wait_nxt = 1'b1;
            end else if (sent != 16'd0) begin
              desc_valid       = 1'b1;
              desc.kind        = tewf_pkg::SEG_DATA;
              desc.payload_len = sent[9:0];
              next_seq_nxt     = next_seq_r + {16'd0, sent};
            end
          end
        end
        tewf_pkg::CMD_SEGMENT: begin
          if (peer_flags == tewf_pkg::FLAG_FIN) begin
            fin_rcvd_nxt     = 1'b1;
            desc_valid       = 1'b1;
            desc.kind        = tewf_pkg::SEG_ACK;
            desc.fin_ack     = 1'b1;
            desc.ack         = ack_base;
            desc.win         = adv_win_r;
            desc.deliver_len = plen_c;
            if (fin_acked_r) begin
              closed_nxt = 1'b1;
            end
          end else if (peer_flags == tewf_pkg::FLAG_ACK) begin
            acked_nxt   = peer_ack;
            win_end_nxt = tewf_pkg::sat_add(peer_ack, {16'd0, peer_window});
            wait_nxt    = 1'b0;
            if (fin_sent_r && ({1'b0, next_seq_r} + 33'd1 == {1'b0, peer_ack})) begin
              if (fin_rcvd_r) begin
                closed_nxt = 1'b1;
              end else begin
                fin_acked_nxt = 1'b1;
              end
            end
          end else begin
            desc_valid       = 1'b1;
            desc.kind        = tewf_pkg::SEG_ACK;
            desc.ack         = ack_base;
            desc.win         = adv_win_r;
            desc.deliver_len = plen_c;
          end
        end
        tewf_pkg::CMD_CLOSE: begin
          desc_valid   = 1'b1;
          desc.kind    = tewf_pkg::SEG_FIN;
          fin_sent_nxt = 1'b1;
        end
        default: ;
      endcase
    end
    desc.done = closed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_seq_r  <= tewf_pkg::RESET_INIT_SEQ;
      init_win_r  <= tewf_pkg::RESET_WINDOW;
      adv_win_r   <= tewf_pkg::RESET_WINDOW;
      next_seq_r  <= tewf_pkg::RESET_INIT_SEQ + 32'd1;
      acked_r     <= tewf_pkg::RESET_INIT_SEQ;
      win_end_r   <= tewf_pkg::RESET_INIT_SEQ + {16'd0, tewf_pkg::RESET_WINDOW};
      wait_r      <= 1'b0;
      fin_sent_r  <= 1'b0;
      fin_rcvd_r  <= 1'b0;
      fin_acked_r <= 1'b0;
      closed_r    <= 1'b0;
    end else begin
      init_seq_r  <= init_seq_nxt;
      init_win_r  <= init_win_nxt;
      adv_win_r   <= adv_win_nxt;
      next_seq_r  <= next_seq_nxt;
      acked_r     <= acked_nxt;
      win_end_r   <= win_end_nxt;
      wait_r      <= wait_nxt;
      fin_sent_r  <= fin_sent_nxt;
      fin_rcvd_r  <= fin_rcvd_nxt;
      fin_acked_r <= fin_acked_nxt;
      closed_r    <= closed_nxt;
    end
  end

`ifndef SYNTH
  a_fin_acked_needs_fin_sent: assert property (@(posedge clk) disable iff (!rst_n)
    fin_acked_r |-> fin_sent_r) else $error("own FIN acked without FIN sent");
  a_closed_needs_fin_sent: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> fin_sent_r) else $error("connection closed without FIN sent");
  a_data_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (desc_valid && desc.kind == tewf_pkg::SEG_DATA) |-> desc.payload_len != 10'd0)
    else $error("empty data segment queued");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tewf_queue.sv =====
// Short queue of event descriptors between the front and back ends.
`default_nettype none
module tewf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  tewf_pkg::desc_t      wr_data,
  output logic                 full,
  input  wire logic            pop,
  output tewf_pkg::desc_t      rd_data,
  output logic                 empty
);

  localparam int PTR_W = (tewf_pkg::QUEUE_DEPTH > 1) ? $clog2(tewf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tewf_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(tewf_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(tewf_pkg::QUEUE_DEPTH - 1);

  tewf_pkg::desc_t  entries [tewf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == DEPTH);
  assign empty   = (count_r == '0);
  assign rd_data = entries[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tewf_back.sv =====
// Back end: expands queued events into outgoing segment beats.
`default_nettype none
module tewf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  tewf_pkg::desc_t      head,
  input  wire logic            head_valid,
  output logic                 head_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [1:0]           out_segment_kind,
  output logic [31:0]          out_segment_seq,
  output logic [31:0]          out_segment_ack,
  output logic [15:0]          out_segment_window,
  output logic [9:0]           out_segment_payload_len,
  output logic [9:0]           out_deliver_len,
  output logic                 out_connection_done,
  output logic                 out_last_result
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  kind_r;
  logic [31:0] seq_r;
  logic [31:0] ack_r;
  logic [15:0] win_r;
  logic [9:0]  plen_r;
  logic [9:0]  dlen_r;
  logic        done_r;
  logic        last_r;

  logic        load;
  logic        first;
  logic [31:0] ack_val;
  logic [9:0]  dlen_val;

  always_comb begin
    load      = head_valid && (!valid_r || out_pop);
    first     = head.fin_ack && (head.deliver_len != 10'd0) && !phase_r;
    ack_val   = (head.fin_ack && !first) ? head.ack + 32'd1 : head.ack;
    dlen_val  = (head.fin_ack && !first) ? 10'd0 : head.deliver_len;
    head_pop  = load && !first;
    phase_nxt = load ? first : phase_r;
    valid_nxt = load || (valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head.kind;
      seq_r  <= head.seq;
      ack_r  <= ack_val;
      win_r  <= head.win;
      plen_r <= head.payload_len;
      dlen_r <= dlen_val;
      done_r <= head.done;
      last_r <= !first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign out_empty               = !valid_r;
  assign out_segment_kind        = kind_r;
  assign out_segment_seq         = seq_r;
  assign out_segment_ack         = ack_r;
  assign out_segment_window      = win_r;
  assign out_segment_payload_len = plen_r;
  assign out_deliver_len         = dlen_r;
  assign out_connection_done     = done_r;
  assign out_last_result         = last_r;

`ifndef SYNTH
  a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> head_valid) else $error("second half pending without its event");
  a_non_last_is_payload_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r) |-> (kind_r == tewf_pkg::SEG_ACK && dlen_r != 10'd0))
    else $error("non-final beat is not a payload ack");
  a_pop_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> (load && !first)) else $error("event dropped before final beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/transport_endpoint_window_fin.sv =====
// Top level of the established-state sliding-window transport endpoint.
// The endpoint takes one event per cycle (app data, received segment, close or
// timeout) while its two-entry event queue has room, updates the connection
// state in that same cycle and queues the segments the event causes. The back
// end sends one result beat per cycle from an output register while results
// are popped; an event causes at most one beat, except a FIN with payload,
// which causes two, and the back end's single output register sets that rate.
// An accepted event passes through its queue entry and then the back end's
// output register before its result is on the result ports. Writing register 0
// reloads the whole connection state from the new initial sequence.
`default_nettype none
module transport_endpoint_window_fin #(
  parameter int unsigned MAX_SEGMENT_BYTES = 536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_app_offered_len,
  input  wire logic [7:0]  in_peer_flags,
  input  wire logic [31:0] in_peer_seq,
  input  wire logic [31:0] in_peer_ack,
  input  wire logic [15:0] in_peer_window,
  input  wire logic [9:0]  in_peer_payload_len,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_segment_kind,
  output logic [31:0]      out_segment_seq,
  output logic [31:0]      out_segment_ack,
  output logic [15:0]      out_segment_window,
  output logic [9:0]       out_segment_payload_len,
  output logic [9:0]       out_deliver_len,
  output logic             out_connection_done,
  output logic             out_last_result
);

  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            desc_valid;
  tewf_pkg::desc_t desc;
  tewf_pkg::desc_t head;

  assign in_full = q_full;

  tewf_front #(
    .MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accept           (in_push && !q_full),
    .command          (in_command),
    .app_offered_len  (in_app_offered_len),
    .peer_flags       (in_peer_flags),
    .peer_seq         (in_peer_seq),
    .peer_ack         (in_peer_ack),
    .peer_window      (in_peer_window),
    .peer_payload_len (in_peer_payload_len),
    .desc_valid       (desc_valid),
    .desc             (desc)
  );

  tewf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (desc_valid),
    .wr_data (desc),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  tewf_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .head                    (head),
    .head_valid              (!q_empty),
    .head_pop                (q_pop),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_segment_kind        (out_segment_kind),
    .out_segment_seq         (out_segment_seq),
    .out_segment_ack         (out_segment_ack),
    .out_segment_window      (out_segment_window),
    .out_segment_payload_len (out_segment_payload_len),
    .out_deliver_len         (out_deliver_len),
    .out_connection_done     (out_connection_done),
    .out_last_result         (out_last_result)
  );

endmodule
`default_nettype wire
